### src/sled_pkg.sv
// Shared types and constants for the scanline edge locator.
`default_nettype none
package sled_pkg;

	localparam int PIX_W     = 8;
	localparam int RUN_W     = 8;
	localparam int EDGE_W    = 12;
	localparam int ERR_W     = 26;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 8;
	localparam int SCALE     = 10000;
	localparam int SCALE_W   = 14;

	localparam logic [CFG_W-1:0] HIGH_THR_RST = 8'd220;
	localparam logic [CFG_W-1:0] LOW_THR_RST  = 8'd150;
	localparam logic [CFG_W-1:0] MIN_RUN_RST  = 8'd3;
	localparam logic [RUN_W-1:0] RUN_MAX      = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HIGH_THR = 2'd0,
		REG_LOW_THR  = 2'd1,
		REG_MIN_RUN  = 2'd2
	} sled_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} sled_state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic mul;
		logic step;
	} sled_cmd_t;

	typedef struct packed {
		logic last_step;
	} sled_stat_t;

endpackage
`default_nettype wire

### src/sled_if.sv
// Pixel and result channel interfaces.
`default_nettype none
interface sled_pixel_if;
	logic                       valid;
	logic                       ready;
	logic [sled_pkg::PIX_W-1:0] pixel_value;
	logic                       line_end;

	modport source (output valid, pixel_value, line_end, input ready);
	modport sink (input valid, pixel_value, line_end, output ready);
endinterface

interface sled_result_if;
	logic                        valid;
	logic                        ready;
	logic [sled_pkg::EDGE_W-1:0] left_edge;
	logic [sled_pkg::EDGE_W-1:0] right_edge;
	logic [sled_pkg::EDGE_W-1:0] midpoint;
	logic [sled_pkg::ERR_W-1:0]  error_centi_percent;
	logic                        left_found;
	logic                        right_found;

	modport source (output valid, left_edge, right_edge, midpoint, error_centi_percent,
		left_found, right_found, input ready);
	modport sink (input valid, left_edge, right_edge, midpoint, error_centi_percent,
		left_found, right_found, output ready);
endinterface
`default_nettype wire

### src/scanline_line_edge_locator_unit.sv
// Top level of the scanline edge locator.
//
//  port      dir  beat contents
//  in_ch     in   pixel_value, line_end
//  out_ch    out  left_edge, right_edge, midpoint, error_centi_percent, found flags
//  cfg_*     in   one register write per cycle while cfg_we is high
//
// Pixels are taken one per cycle. A line-end beat starts the result calculation:
// the PREP state forms midpoint and offset, the MUL state the x10000 multiply, then
// the DIV state runs the shift-subtract divider, and the OUT state presents the result beat.
// Mid-line pixels of the next line keep flowing meanwhile; the next line-end beat
// waits until the previous result has been taken. Reset restores default thresholds.
`default_nettype none
module scanline_line_edge_locator_unit #(
	parameter int MAX_PIXELS = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [sled_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sled_pkg::CFG_W-1:0]     cfg_data,
	sled_pixel_if.sink                         in_ch,
	sled_result_if.source                      out_ch
);
	import sled_pkg::*;

	localparam int IW = $clog2(MAX_PIXELS);

	sled_cmd_t     cmd;
	sled_stat_t    stat;
	logic          busy, in_fire;
	logic [IW-1:0] sum_left, sum_right, sum_idx;
	logic          sum_lf, sum_rf;

	assign in_fire = in_ch.valid && in_ch.ready;

	sled_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_line_end (in_ch.line_end),
		.in_ready    (in_ch.ready),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.stat        (stat),
		.cmd         (cmd),
		.busy        (busy)
	);

	sled_front #(
		.MAX_PIXELS (MAX_PIXELS),
		.IW         (IW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fire        (in_fire),
		.pixel_value (in_ch.pixel_value),
		.line_end    (in_ch.line_end),
		.sum_left    (sum_left),
		.sum_right   (sum_right),
		.sum_idx     (sum_idx),
		.sum_lf      (sum_lf),
		.sum_rf      (sum_rf)
	);

	sled_calc #(
		.IW (IW)
	) u_calc (
		.clk                 (clk),
		.cmd                 (cmd),
		.stat                (stat),
		.sum_left            (sum_left),
		.sum_right           (sum_right),
		.sum_idx             (sum_idx),
		.sum_lf              (sum_lf),
		.sum_rf              (sum_rf),
		.left_edge           (out_ch.left_edge),
		.right_edge          (out_ch.right_edge),
		.midpoint            (out_ch.midpoint),
		.error_centi_percent (out_ch.error_centi_percent),
		.left_found          (out_ch.left_found),
		.right_found         (out_ch.right_found)
	);

	a_line_end_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_ch.line_end) |=> busy)
		else $error("line-end beat did not start result calculation");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !out_ch.valid)
		else $error("result valid while idle");

	a_left_default: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.left_found) |-> (out_ch.left_edge == EDGE_W'(1)))
		else $error("missing left edge not reported as one");

	a_right_default: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.right_found) |-> (out_ch.right_edge == EDGE_W'(1)))
		else $error("missing right edge not reported as one");

endmodule
`default_nettype wire

### src/sled_ctrl.sv
// Controller state machine: line-end handoff, divide sequencing, result beat.
`default_nettype none
module sled_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_line_end,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire sled_pkg::sled_stat_t stat,
	output sled_pkg::sled_cmd_t  cmd,
	output logic               busy
);
	import sled_pkg::*;

	sled_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		out_valid = 1'b0;
		in_ready  = !in_line_end;
		busy      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				in_ready = 1'b1;
				if (in_valid && in_line_end) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (stat.last_step) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

### src/sled_front.sv
// Per-pixel datapath: config registers, run counting and edge capture.
`default_nettype none
module sled_front #(
	parameter int MAX_PIXELS = 4096,
	parameter int IW         = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [sled_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sled_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          fire,
	input  wire logic [sled_pkg::PIX_W-1:0]     pixel_value,
	input  wire logic                          line_end,
	output logic [IW-1:0]                      sum_left,
	output logic [IW-1:0]                      sum_right,
	output logic [IW-1:0]                      sum_idx,
	output logic                               sum_lf,
	output logic                               sum_rf
);
	import sled_pkg::*;

	localparam int XW = IW + 9;

	logic [CFG_W-1:0] high_thr_q, low_thr_q, min_run_q;
	logic [IW-1:0]    pixel_index_q, rise_pos_q, fall_pos_q;
	logic [RUN_W-1:0] run_count_q;
	logic             rise_seen_q, armed_q, fall_seen_q;

	logic [RUN_W-1:0] need, run_inc, run_n;
	logic             bright, rise_now, fall_now;
	logic [XW-1:0]    pos_ext, need_ext;
	logic [IW-1:0]    rise_pos_n, fall_pos_n, rise_val, fall_val;
	logic             rise_seen_n, fall_seen_n, armed_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q <= HIGH_THR_RST;
			low_thr_q  <= LOW_THR_RST;
			min_run_q  <= MIN_RUN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HIGH_THR: high_thr_q <= cfg_data;
				REG_LOW_THR:  low_thr_q  <= cfg_data;
				REG_MIN_RUN:  min_run_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		need     = (min_run_q == '0) ? RUN_W'(1) : min_run_q;
		bright   = pixel_value >= high_thr_q;
		run_inc  = (run_count_q < RUN_MAX) ? run_count_q + RUN_W'(1) : run_count_q;
		run_n    = bright ? run_inc : '0;
		rise_now = bright && (run_inc >= need) && !rise_seen_q;
		fall_now = !bright && armed_q && (pixel_value < low_thr_q);
		pos_ext  = XW'(pixel_index_q) + XW'(1);
		need_ext = XW'(need);
		rise_pos_n  = rise_now ? ((pos_ext >= need_ext) ? IW'(pos_ext - need_ext) : '0)
			: rise_pos_q;
		rise_seen_n = rise_seen_q || rise_now;
		fall_pos_n  = fall_now ? pixel_index_q : fall_pos_q;
		fall_seen_n = fall_seen_q || fall_now;
		armed_n     = rise_now ? 1'b1 : (fall_now ? 1'b0 : armed_q);
		rise_val    = rise_seen_n ? rise_pos_n : '0;
		fall_val    = fall_seen_n ? fall_pos_n : '0;
		// missing or zero edge reads as one
		sum_left    = (rise_val == '0) ? IW'(1) : rise_val;
		sum_right   = (fall_val == '0) ? IW'(1) : fall_val;
		sum_idx     = pixel_index_q;
		sum_lf      = rise_seen_n;
		sum_rf      = fall_seen_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_index_q <= '0;
			run_count_q   <= '0;
			rise_seen_q   <= 1'b0;
			rise_pos_q    <= '0;
			armed_q       <= 1'b0;
			fall_seen_q   <= 1'b0;
			fall_pos_q    <= '0;
		end else if (fire) begin
			if (line_end) begin
				pixel_index_q <= '0;
				run_count_q   <= '0;
				rise_seen_q   <= 1'b0;
				rise_pos_q    <= '0;
				armed_q       <= 1'b0;
				fall_seen_q   <= 1'b0;
				fall_pos_q    <= '0;
			end else begin
				if (pixel_index_q < IW'(MAX_PIXELS - 1)) begin
					pixel_index_q <= pixel_index_q + IW'(1);
				end
				run_count_q <= run_n;
				rise_seen_q <= rise_seen_n;
				rise_pos_q  <= rise_pos_n;
				armed_q     <= armed_n;
				fall_seen_q <= fall_seen_n;
				fall_pos_q  <= fall_pos_n;
			end
		end
	end

endmodule
`default_nettype wire

### src/sled_calc.sv
// Line-end datapath: midpoint, scaled offset, restoring divider, result register.
`default_nettype none
module sled_calc #(
	parameter int IW = 12
) (
	input  wire logic                       clk,
	input  wire sled_pkg::sled_cmd_t        cmd,
	output sled_pkg::sled_stat_t            stat,
	input  wire logic [IW-1:0]              sum_left,
	input  wire logic [IW-1:0]              sum_right,
	input  wire logic [IW-1:0]              sum_idx,
	input  wire logic                       sum_lf,
	input  wire logic                       sum_rf,
	output logic [sled_pkg::EDGE_W-1:0]     left_edge,
	output logic [sled_pkg::EDGE_W-1:0]     right_edge,
	output logic [sled_pkg::EDGE_W-1:0]     midpoint,
	output logic [sled_pkg::ERR_W-1:0]      error_centi_percent,
	output logic                            left_found,
	output logic                            right_found
);
	import sled_pkg::*;

	localparam int QW = IW + SCALE_W;
	localparam int CW = $clog2(QW);

	logic [IW-1:0] left_q, right_q, idx_q, mid_q, diff_q, rem_q;
	logic          lf_q, rf_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;

	logic [IW:0]   edge_sum, cnt_sum, trial;
	logic [IW-1:0] mid_n, center;
	logic          ge;

	always_comb begin
		edge_sum = (IW+1)'(left_q) + (IW+1)'(right_q);
		mid_n    = IW'(edge_sum >> 1);
		cnt_sum  = (IW+1)'(idx_q) + (IW+1)'(1);
		center   = IW'(cnt_sum >> 1);
		trial    = {rem_q, quo_q[QW-1]};
		ge       = trial >= {1'b0, mid_q};
		stat.last_step = cnt_q == CW'(QW - 1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			left_q  <= sum_left;
			right_q <= sum_right;
			idx_q   <= sum_idx;
			lf_q    <= sum_lf;
			rf_q    <= sum_rf;
		end
		if (cmd.prep) begin
			mid_q  <= mid_n;
			diff_q <= (center > mid_n) ? center - mid_n : mid_n - center;
		end
		if (cmd.mul) begin
			quo_q <= QW'(diff_q) * QW'(SCALE);
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.step) begin
			rem_q <= ge ? IW'(trial - {1'b0, mid_q}) : IW'(trial);
			quo_q <= {quo_q[QW-2:0], ge};
			cnt_q <= cnt_q + CW'(1);
		end
	end

	assign left_edge           = EDGE_W'(left_q);
	assign right_edge          = EDGE_W'(right_q);
	assign midpoint            = EDGE_W'(mid_q);
	assign error_centi_percent = ERR_W'(quo_q);
	assign left_found          = lf_q;
	assign right_found         = rf_q;

endmodule
`default_nettype wire
